/* hw/rtl/hlm_pkg.sv */
`timescale 1ns / 1ps

package hlm_pkg;

    localparam int DEF_MAX_WIDTH   = 64;
    localparam int DEF_MAX_HEIGHT  = 64;
    localparam int DEF_SAMPLE_BITS = 32;

    // log2 sizes and line indexes, sized for the largest supported tile
    localparam int LOG_BITS      = 4;
    localparam int JOB_LINE_BITS = 10;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_RUN   = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic [1:0] CFG_WIDTH_LOG2  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT_LOG2 = 2'd1;
    localparam logic [1:0] CFG_INVERSE     = 2'd2;
    localparam logic [1:0] CFG_SUBTILE     = 2'd3;

    typedef struct packed {
        logic                     valid;
        logic                     col_line;
        logic [JOB_LINE_BITS-1:0] line;
        logic [LOG_BITS-1:0]      nlog;
    } job_t;

endpackage

/* hw/rtl/hlm_lift.sv */
`timescale 1ns / 1ps

module hlm_lift #(
    parameter int SAMPLE_BITS = hlm_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          clk,
    input  logic                          inv,
    input  logic                          s1_en,
    input  logic                          s2_en,
    input  logic signed [SAMPLE_BITS-1:0] x0,
    input  logic signed [SAMPLE_BITS-1:0] x1,
    output logic signed [SAMPLE_BITS-1:0] y0,
    output logic signed [SAMPLE_BITS-1:0] y1
);
    import hlm_pkg::*;

    localparam int W = SAMPLE_BITS + 3;
    localparam logic signed [W-1:0] I64_MAX = W'($signed(64'h7FFF_FFFF_FFFF_FFFF));
    localparam logic signed [W-1:0] I64_MIN = W'($signed(64'h8000_0000_0000_0000));
    localparam logic signed [W-1:0] S_MAX =
        $signed(W'((W'(1) << (SAMPLE_BITS - 1)) - W'(1)));
    localparam logic signed [W-1:0] S_MIN = ~S_MAX;

    function automatic logic signed [W-1:0] sat_wide(input logic signed [W-1:0] x);
        logic signed [W-1:0] r;
        r = x;
        if (W > 64)
        begin
            if (x > I64_MAX)
                r = I64_MAX;
            else if (x < I64_MIN)
                r = I64_MIN;
        end
        return r;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] clamp_s(input logic signed [W-1:0] x);
        logic signed [W-1:0] r;
        r = x;
        if (x > S_MAX)
            r = S_MAX;
        else if (x < S_MIN)
            r = S_MIN;
        return r[SAMPLE_BITS-1:0];
    endfunction

    logic signed [W-1:0] xa;
    logic signed [W-1:0] xb;
    logic signed [W-1:0] hh;
    logic signed [W-1:0] d_next;
    logic signed [W-1:0] d_reg;
    logic signed [W-1:0] a_reg;
    logic signed [W-1:0] even;
    logic signed [SAMPLE_BITS-1:0] y0_next;
    logic signed [SAMPLE_BITS-1:0] y1_next;
    logic signed [SAMPLE_BITS-1:0] y0_reg;
    logic signed [SAMPLE_BITS-1:0] y1_reg;

    // stage 1: difference (forward) or doubled negated high (inverse)
    always_comb
    begin
        xa = W'(x0);
        xb = W'(x1);
        hh = sat_wide(xb + xb);
        if (inv)
            d_next = sat_wide(-hh);
        else
            d_next = sat_wide(xb - xa);
    end

    // stage 2: low/high or even/odd
    always_comb
    begin
        even = sat_wide(a_reg - (d_reg >>> 1));
        if (inv)
        begin
            y0_next = clamp_s(even);
            y1_next = clamp_s(sat_wide(d_reg + even));
        end
        else
        begin
            y0_next = clamp_s(sat_wide(a_reg + (d_reg >>> 1)));
            y1_next = clamp_s(sat_wide(-d_reg) >>> 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            d_reg <= d_next;
            a_reg <= xa;
        end
        if (s2_en)
        begin
            y0_reg <= y0_next;
            y1_reg <= y1_next;
        end
    end

    assign y0 = y0_reg;
    assign y1 = y1_reg;

endmodule

/* hw/rtl/hlm_sched.sv */
`timescale 1ns / 1ps

module hlm_sched #(
    parameter int MAX_WIDTH  = hlm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = hlm_pkg::DEF_MAX_HEIGHT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              inverse,
    input  logic              subtile,
    input  logic [2:0]        width_log2,
    input  logic [2:0]        height_log2,
    input  logic              advance,
    output hlm_pkg::job_t     job,
    output logic              done
);
    import hlm_pkg::*;

    localparam int LGW = $clog2(MAX_WIDTH);
    localparam int LGH = $clog2(MAX_HEIGHT);
    localparam logic [JOB_LINE_BITS:0] ONE = 1;

    typedef enum logic [3:0] {
        S_IDLE, S_F2C, S_F2R, S_F1R, S_F1C, S_I1R, S_I1C, S_I2R, S_I2C, S_DONE
    } phase_t;

    phase_t                   phase_reg;
    logic [LOG_BITS-1:0]      lw_reg;
    logic [LOG_BITS-1:0]      lh_reg;
    logic [LOG_BITS-1:0]      k_reg;
    logic [LOG_BITS-1:0]      lev_reg;
    logic [JOB_LINE_BITS-1:0] idx_reg;

    logic [LOG_BITS-1:0]      elw;
    logic [LOG_BITS-1:0]      elh;
    logic [LOG_BITS-1:0]      emin;
    logic [LOG_BITS-1:0]      levels;
    logic [JOB_LINE_BITS:0]   last_w;
    logic [JOB_LINE_BITS:0]   last_h;
    logic                     idx_last_w;
    logic                     idx_last_h;

    always_comb
    begin
        elw    = (width_log2 > LGW) ? LOG_BITS'(LGW) : LOG_BITS'(width_log2);
        elh    = (height_log2 > LGH) ? LOG_BITS'(LGH) : LOG_BITS'(height_log2);
        emin   = (elw < elh) ? elw : elh;
        levels = (emin != '0) ? emin - LOG_BITS'(1) : '0;
        last_w = (ONE << lw_reg) - ONE;
        last_h = (ONE << lh_reg) - ONE;
        idx_last_w = ({1'b0, idx_reg} == last_w);
        idx_last_h = ({1'b0, idx_reg} == last_h);
    end

    always_comb
    begin
        job.valid    = 1'b0;
        job.col_line = 1'b0;
        job.line     = idx_reg;
        job.nlog     = lw_reg;
        unique case (phase_reg)
            S_F2C:
            begin
                job.valid    = (lw_reg != '0) && (lh_reg != '0);
                job.col_line = 1'b1;
                job.nlog     = lh_reg;
            end
            S_F2R:
            begin
                job.valid = 1'b1;
            end
            S_F1R:
            begin
                job.valid = !subtile && (lw_reg != '0);
                job.line  = '0;
            end
            S_F1C:
            begin
                job.valid    = !subtile && (lh_reg != '0);
                job.col_line = 1'b1;
                job.line     = '0;
                job.nlog     = lh_reg;
            end
            S_I1R:
            begin
                job.valid = (k_reg < lw_reg);
                job.line  = '0;
                job.nlog  = k_reg;
            end
            S_I1C:
            begin
                job.valid    = (k_reg < lh_reg);
                job.col_line = 1'b1;
                job.line     = '0;
                job.nlog     = k_reg;
            end
            S_I2R:
            begin
                job.valid = 1'b1;
            end
            S_I2C:
            begin
                job.valid    = 1'b1;
                job.col_line = 1'b1;
                job.nlog     = lh_reg;
            end
            S_IDLE, S_DONE:
            begin
                job.valid = 1'b0;
            end
            default:
            begin
                job.valid = 1'b0;
            end
        endcase
    end

    assign done = (phase_reg == S_DONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= S_IDLE;
            lw_reg    <= '0;
            lh_reg    <= '0;
            k_reg     <= '0;
            lev_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            unique case (phase_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        idx_reg <= '0;
                        k_reg   <= LOG_BITS'(1);
                        if (inverse)
                        begin
                            lw_reg    <= elw - levels;
                            lh_reg    <= elh - levels;
                            lev_reg   <= levels;
                            phase_reg <= subtile ? S_I2R : S_I1R;
                        end
                        else
                        begin
                            lw_reg    <= elw;
                            lh_reg    <= elh;
                            phase_reg <= S_F2C;
                        end
                    end
                end
                S_F2C:
                begin
                    if (!job.valid)
                        phase_reg <= S_F1R;
                    else if (advance)
                    begin
                        if (idx_last_w)
                        begin
                            idx_reg   <= '0;
                            phase_reg <= S_F2R;
                        end
                        else
                            idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_F2R:
                begin
                    if (advance)
                    begin
                        if (idx_last_h)
                        begin
                            idx_reg   <= '0;
                            lw_reg    <= lw_reg - 1'b1;
                            lh_reg    <= lh_reg - 1'b1;
                            phase_reg <= S_F2C;
                        end
                        else
                            idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_F1R:
                begin
                    if (!job.valid)
                        phase_reg <= S_F1C;
                    else if (advance)
                        lw_reg <= lw_reg - 1'b1;
                end
                S_F1C:
                begin
                    if (!job.valid)
                        phase_reg <= S_DONE;
                    else if (advance)
                        lh_reg <= lh_reg - 1'b1;
                end
                S_I1R:
                begin
                    if (!job.valid)
                    begin
                        k_reg     <= LOG_BITS'(1);
                        phase_reg <= S_I1C;
                    end
                    else if (advance)
                        k_reg <= k_reg + 1'b1;
                end
                S_I1C:
                begin
                    if (!job.valid)
                        phase_reg <= S_I2R;
                    else if (advance)
                        k_reg <= k_reg + 1'b1;
                end
                S_I2R:
                begin
                    if (advance)
                    begin
                        if (idx_last_h)
                        begin
                            idx_reg   <= '0;
                            phase_reg <= S_I2C;
                        end
                        else
                            idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_I2C:
                begin
                    if (advance)
                    begin
                        if (idx_last_w)
                        begin
                            idx_reg <= '0;
                            if (lev_reg == '0)
                                phase_reg <= S_DONE;
                            else
                            begin
                                lev_reg   <= lev_reg - 1'b1;
                                lw_reg    <= lw_reg + 1'b1;
                                lh_reg    <= lh_reg + 1'b1;
                                phase_reg <= S_I2R;
                            end
                        end
                        else
                            idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_DONE:
                begin
                    phase_reg <= S_IDLE;
                end
                default:
                begin
                    phase_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* hw/rtl/haar_lifting_2d_multilevel_core.sv */
`timescale 1ns / 1ps

// Multi-level 2D Haar lifting transform on a tile held in an internal store.
// Input channel (in_valid/in_ready) takes one command beat: cmd 0 writes
// sample_in at (row_index, col_index), cmd 1 runs the transform in place,
// cmd 2 reads a sample, cmd 3 does nothing. Output channel (out_valid/
// out_ready) returns one beat for a read (result_kind 0, the sample) or for
// a finished run (result_kind 1, sample_out zero). Writes give no beat.
// cfg_we/cfg_index/cfg_data set tile size, direction and subtile mode; write
// them only while the core is idle.
// A write goes into the store as it is accepted; a read passes the store's
// read register and the output register. A run walks the tile line by line
// through one lifting unit: after dispatch (T_JOB) a line is loaded into the
// line buffer from the single-port store (L_RD, L_WR per sample), then each
// pair is lifted and written back (C_RD, C_S1, C_S2, C_WR0, C_WR1), for every
// line of every level; a one-sample line and each phase change take only
// dispatch. in_ready is low for the whole run. A result beat held by a stalled
// receiver blocks new commands until taken. Reset sets a 64x64 forward
// transform without subtile mode; the tile store is undefined until written.

module haar_lifting_2d_multilevel_core #(
    parameter int MAX_WIDTH   = hlm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = hlm_pkg::DEF_MAX_HEIGHT,
    parameter int SAMPLE_BITS = hlm_pkg::DEF_SAMPLE_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [2:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         cmd,
    input  logic [5:0]         row_index,
    input  logic [5:0]         col_index,
    input  logic signed [31:0] sample_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               result_kind,
    output logic signed [31:0] sample_out
);
    import hlm_pkg::*;

    localparam int CB          = $clog2(MAX_WIDTH);
    localparam int RB          = $clog2(MAX_HEIGHT);
    localparam int ADDR_BITS   = RB + CB;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int LINE_DEPTH  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int LB_BITS     = $clog2(LINE_DEPTH);
    localparam logic [JOB_LINE_BITS:0] ONE = 1;
    localparam logic signed [64:0] IN_MAX =
        $signed((65'd1 << (SAMPLE_BITS - 1)) - 65'd1);
    localparam logic signed [64:0] IN_MIN = ~IN_MAX;

    typedef enum logic [3:0] {
        T_IDLE, T_RDWAIT, T_JOB, L_RD, L_WR, C_RD, C_S1, C_S2, C_WR0, C_WR1
    } state_t;

    function automatic logic [ADDR_BITS-1:0] tile_addr(
        input logic                     col_line,
        input logic [JOB_LINE_BITS-1:0] line,
        input logic [JOB_LINE_BITS:0]   pos
    );
        logic [JOB_LINE_BITS:0] r;
        logic [JOB_LINE_BITS:0] c;
        r = col_line ? pos : {1'b0, line};
        c = col_line ? {1'b0, line} : pos;
        return {r[RB-1:0], c[CB-1:0]};
    endfunction

    // configuration
    logic [2:0] width_log2_reg;
    logic [2:0] height_log2_reg;
    logic       inverse_reg;
    logic       subtile_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_log2_reg  <= 3'd6;
            height_log2_reg <= 3'd6;
            inverse_reg     <= 1'b0;
            subtile_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WIDTH_LOG2:  width_log2_reg  <= cfg_data;
                CFG_HEIGHT_LOG2: height_log2_reg <= cfg_data;
                CFG_INVERSE:     inverse_reg     <= cfg_data[0];
                CFG_SUBTILE:     subtile_reg     <= cfg_data[0];
                default:         inverse_reg     <= inverse_reg;
            endcase
        end
    end

    state_t                   state_reg;
    logic                     out_valid_reg;
    logic                     kind_reg;
    logic signed [31:0]       sample_out_reg;
    logic                     rd_inside_reg;
    logic [JOB_LINE_BITS-1:0] p_reg;
    logic [JOB_LINE_BITS-1:0] q_reg;

    job_t job;
    logic sched_done;
    logic sched_start;
    logic advance;

    logic                     in_acc;
    logic [15:0]              host_row;
    logic [15:0]              host_col;
    logic                     in_tile;
    logic [ADDR_BITS-1:0]     host_addr;
    logic signed [64:0]       in_ext;
    logic signed [64:0]       in_sat;

    logic [JOB_LINE_BITS:0]   p_ext;
    logic [JOB_LINE_BITS:0]   q_ext;
    logic [JOB_LINE_BITS:0]   pos_last;
    logic [JOB_LINE_BITS:0]   half;
    logic [JOB_LINE_BITS:0]   lb_widx;
    logic [JOB_LINE_BITS:0]   pos0;
    logic [JOB_LINE_BITS:0]   pos1;
    logic                     p_last;
    logic                     q_last;

    logic                         mem_we;
    logic [ADDR_BITS-1:0]         mem_addr;
    logic signed [SAMPLE_BITS-1:0] mem_wdata;
    logic signed [SAMPLE_BITS-1:0] mem_rdata;
    logic signed [SAMPLE_BITS-1:0] tile_mem [STORE_DEPTH];

    logic                          lb_we;
    logic [LB_BITS-1:0]            lb_waddr;
    logic [LB_BITS-1:0]            lb_raddr0;
    logic [LB_BITS-1:0]            lb_raddr1;
    logic signed [SAMPLE_BITS-1:0] lb_rd0;
    logic signed [SAMPLE_BITS-1:0] lb_rd1;
    logic signed [SAMPLE_BITS-1:0] lb_mem [LINE_DEPTH];

    logic                          s1_en;
    logic                          s2_en;
    logic signed [SAMPLE_BITS-1:0] y0;
    logic signed [SAMPLE_BITS-1:0] y1;

    assign in_ready    = (state_reg == T_IDLE) && (!out_valid_reg || out_ready);
    assign in_acc      = in_valid && in_ready;
    assign sched_start = in_acc && (cmd == CMD_RUN);
    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign sample_out  = sample_out_reg;

    always_comb
    begin
        host_row  = 16'(row_index);
        host_col  = 16'(col_index);
        in_tile   = (host_row < 16'(MAX_HEIGHT)) && (host_col < 16'(MAX_WIDTH));
        host_addr = {host_row[RB-1:0], host_col[CB-1:0]};
        in_ext    = 65'(sample_in);
        if (in_ext > IN_MAX)
            in_sat = IN_MAX;
        else if (in_ext < IN_MIN)
            in_sat = IN_MIN;
        else
            in_sat = in_ext;
    end

    // line positions
    always_comb
    begin
        p_ext    = {1'b0, p_reg};
        q_ext    = {1'b0, q_reg};
        pos_last = (ONE << job.nlog) - ONE;
        half     = ONE << (job.nlog - LOG_BITS'(1));
        p_last   = (p_ext == pos_last);
        q_last   = (q_ext == half - ONE);
        if (!inverse_reg)
            lb_widx = p_ext;
        else if (p_ext < half)
            lb_widx = p_ext << 1;
        else
            lb_widx = ((p_ext - half) << 1) | ONE;
        if (inverse_reg)
        begin
            pos0 = q_ext << 1;
            pos1 = (q_ext << 1) | ONE;
        end
        else
        begin
            pos0 = q_ext;
            pos1 = half + q_ext;
        end
        lb_waddr  = lb_widx[LB_BITS-1:0];
        lb_raddr0 = LB_BITS'(q_ext << 1);
        lb_raddr1 = LB_BITS'((q_ext << 1) | ONE);
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = host_addr;
        mem_wdata = y0;
        lb_we     = 1'b0;
        s1_en     = 1'b0;
        s2_en     = 1'b0;
        advance   = 1'b0;
        unique case (state_reg)
            T_IDLE:
            begin
                mem_we    = in_acc && (cmd == CMD_WRITE) && in_tile;
                mem_wdata = in_sat[SAMPLE_BITS-1:0];
            end
            T_JOB:
            begin
                advance = job.valid && !sched_done && (job.nlog == '0);
            end
            L_RD:
            begin
                mem_addr = tile_addr(job.col_line, job.line, p_ext);
            end
            L_WR:
            begin
                lb_we = 1'b1;
            end
            C_S1:
            begin
                s1_en = 1'b1;
            end
            C_S2:
            begin
                s2_en = 1'b1;
            end
            C_WR0:
            begin
                mem_we    = 1'b1;
                mem_addr  = tile_addr(job.col_line, job.line, pos0);
                mem_wdata = y0;
            end
            C_WR1:
            begin
                mem_we    = 1'b1;
                mem_addr  = tile_addr(job.col_line, job.line, pos1);
                mem_wdata = y1;
                advance   = q_last;
            end
            T_RDWAIT, C_RD:
            begin
                mem_we = 1'b0;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            tile_mem[mem_addr] <= mem_wdata;
        mem_rdata <= tile_mem[mem_addr];
    end

    always_ff @(posedge clk)
    begin
        if (lb_we)
            lb_mem[lb_waddr] <= mem_rdata;
        lb_rd0 <= lb_mem[lb_raddr0];
        lb_rd1 <= lb_mem[lb_raddr1];
    end

    hlm_lift #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_lift (
        .clk   (clk),
        .inv   (inverse_reg),
        .s1_en (s1_en),
        .s2_en (s2_en),
        .x0    (lb_rd0),
        .x1    (lb_rd1),
        .y0    (y0),
        .y1    (y1)
    );

    hlm_sched #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_sched (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (sched_start),
        .inverse     (inverse_reg),
        .subtile     (subtile_reg),
        .width_log2  (width_log2_reg),
        .height_log2 (height_log2_reg),
        .advance     (advance),
        .job         (job),
        .done        (sched_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= T_IDLE;
            out_valid_reg  <= 1'b0;
            kind_reg       <= KIND_READ;
            sample_out_reg <= '0;
            rd_inside_reg  <= 1'b0;
            p_reg          <= '0;
            q_reg          <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                T_IDLE:
                begin
                    if (in_acc && (cmd == CMD_READ))
                    begin
                        rd_inside_reg <= in_tile;
                        state_reg     <= T_RDWAIT;
                    end
                    else if (sched_start)
                        state_reg <= T_JOB;
                end
                T_RDWAIT:
                begin
                    out_valid_reg  <= 1'b1;
                    kind_reg       <= KIND_READ;
                    sample_out_reg <= rd_inside_reg ? 32'(mem_rdata) : '0;
                    state_reg      <= T_IDLE;
                end
                T_JOB:
                begin
                    if (sched_done)
                    begin
                        out_valid_reg  <= 1'b1;
                        kind_reg       <= KIND_DONE;
                        sample_out_reg <= '0;
                        state_reg      <= T_IDLE;
                    end
                    else if (job.valid && (job.nlog != '0))
                    begin
                        p_reg     <= '0;
                        state_reg <= L_RD;
                    end
                end
                L_RD:
                begin
                    state_reg <= L_WR;
                end
                L_WR:
                begin
                    if (p_last)
                    begin
                        q_reg     <= '0;
                        state_reg <= C_RD;
                    end
                    else
                    begin
                        p_reg     <= p_reg + 1'b1;
                        state_reg <= L_RD;
                    end
                end
                C_RD:
                begin
                    state_reg <= C_S1;
                end
                C_S1:
                begin
                    state_reg <= C_S2;
                end
                C_S2:
                begin
                    state_reg <= C_WR0;
                end
                C_WR0:
                begin
                    state_reg <= C_WR1;
                end
                C_WR1:
                begin
                    if (q_last)
                        state_reg <= T_JOB;
                    else
                    begin
                        q_reg     <= q_reg + 1'b1;
                        state_reg <= C_RD;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    // scheduler never offers a line in the cycle it reports completion
    a_done_no_job: assert property (@(posedge clk) disable iff (!rst_n)
        !(sched_done && job.valid))
        else $error("scheduler done with a pending line");

    // a run command always hands control to the line walk
    a_run_to_job: assert property (@(posedge clk) disable iff (!rst_n)
        sched_start |=> (state_reg == T_JOB))
        else $error("run not started");

    // results appear only from a read wait or a finished run
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |->
            ($past(state_reg) == T_RDWAIT) || ($past(state_reg) == T_JOB))
        else $error("result beat from unexpected state");

    // pair counter stays inside the first half of the line
    a_pair_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == C_WR1) |-> (q_ext < half))
        else $error("pair index beyond line");

    // no command is taken while a line is in flight
    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != T_IDLE) |-> !in_ready)
        else $error("input accepted while busy");

endmodule

/* tb/tb_haar_lifting_2d_multilevel_core.sv */
`timescale 1ns / 1ps

module tb_haar_lifting_2d_multilevel_core;
    import hlm_pkg::*;

    localparam int TILE_W = 64;
    localparam int TILE_H = 64;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic [1:0]  cmd;
        logic [5:0]  row;
        logic [5:0]  col;
        logic [31:0] data;
    } cmd_beat_t;

    typedef struct {
        logic        kind;
        logic [31:0] sample;
    } result_beat_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [2:0]         cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         cmd;
    logic [5:0]         row_index;
    logic [5:0]         col_index;
    logic signed [31:0] sample_in;
    logic               out_valid;
    logic               out_ready;
    logic               result_kind;
    logic signed [31:0] sample_out;

    cmd_beat_t    beat_queue[$];
    result_beat_t awaited_results[$];

    longint tile_model[0:TILE_W*TILE_H-1];
    longint line_work[0:63];
    bit     written[0:TILE_W*TILE_H-1];

    int  mirror_wlog;
    int  mirror_hlog;
    bit  mirror_inverse;
    bit  mirror_subtile;

    int  error_count;
    int  n_writes;
    int  n_reads;
    int  n_runs;
    int  n_pushed;
    bit  calm;
    bit  hold_req;
    bit  hold_done;
    int  hold_cnt;
    int  quiet_cycles;

    haar_lifting_2d_multilevel_core uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .cmd(cmd),
        .row_index(row_index),
        .col_index(col_index),
        .sample_in(sample_in),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .result_kind(result_kind),
        .sample_out(sample_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic longint sat32(longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint half_floor(longint x);
        return x >>> 1;
    endfunction

    function automatic int side_len(int lg, int limit);
        int n;
        n = 1 << lg;
        while (n > limit)
            n = n >> 1;
        return n;
    endfunction

    function automatic void lift_fwd(int base, int n, int stride);
        int half;
        longint a;
        longint b;
        longint d;
        half = n / 2;
        if (n < 2)
            return;
        for (int i = 0; i < n; i++)
            line_work[i] = tile_model[base + i * stride];
        for (int i = 0; i < half; i++)
        begin
            a = line_work[2 * i];
            b = line_work[2 * i + 1];
            d = b - a;
            tile_model[base + i * stride] = sat32(a + half_floor(d));
            tile_model[base + (half + i) * stride] = sat32(half_floor(-d));
        end
    endfunction

    function automatic void lift_inv(int base, int n, int stride);
        int half;
        longint hv;
        longint dd;
        longint even;
        half = n / 2;
        if (n < 2)
            return;
        for (int i = 0; i < half; i++)
        begin
            line_work[2 * i] = tile_model[base + i * stride];
            line_work[2 * i + 1] = tile_model[base + (half + i) * stride];
        end
        for (int i = 0; i < half; i++)
        begin
            hv = line_work[2 * i + 1];
            dd = -(hv + hv);
            even = line_work[2 * i] - half_floor(dd);
            tile_model[base + 2 * i * stride] = sat32(even);
            tile_model[base + (2 * i + 1) * stride] = sat32(dd + even);
        end
    endfunction

    function automatic void haar_forward(int w, int h);
        while (w > 1 && h > 1)
        begin
            for (int i = 0; i < w; i++)
                lift_fwd(i, h, TILE_W);
            for (int i = 0; i < h; i++)
                lift_fwd(i * TILE_W, w, 1);
            w = w >> 1;
            h = h >> 1;
        end
        if (mirror_subtile)
            return;
        while (w > 1)
        begin
            lift_fwd(0, w, 1);
            w = w >> 1;
        end
        while (h > 1)
        begin
            lift_fwd(0, h, TILE_W);
            h = h >> 1;
        end
    endfunction

    function automatic void haar_inverse(int w, int h);
        int levels;
        int wl;
        int hl;
        levels = 0;
        wl = 0;
        hl = 0;
        while (w > 2 && h > 2)
        begin
            levels++;
            w = w >> 1;
            h = h >> 1;
        end
        if (!mirror_subtile)
        begin
            while (w > 2)
            begin
                wl++;
                w = w >> 1;
            end
            while (h > 2)
            begin
                hl++;
                h = h >> 1;
            end
            for (int i = 0; i < wl; i++)
            begin
                lift_inv(0, w, 1);
                w = w << 1;
            end
            for (int i = 0; i < hl; i++)
            begin
                lift_inv(0, h, TILE_W);
                h = h << 1;
            end
        end
        for (int l = 0; l <= levels; l++)
        begin
            for (int i = 0; i < h; i++)
                lift_inv(i * TILE_W, w, 1);
            for (int i = 0; i < w; i++)
                lift_inv(i, h, TILE_H * 0 + TILE_W);
            w = w << 1;
            h = h << 1;
        end
    endfunction

    function automatic void predict_beat(cmd_beat_t b);
        int addr;
        result_beat_t r;
        addr = int'(b.row) * TILE_W + int'(b.col);
        case (b.cmd)
            CMD_WRITE:
            begin
                tile_model[addr] = longint'(signed'(b.data));
                n_writes++;
            end
            CMD_RUN:
            begin
                if (mirror_inverse)
                    haar_inverse(side_len(mirror_wlog, TILE_W), side_len(mirror_hlog, TILE_H));
                else
                    haar_forward(side_len(mirror_wlog, TILE_W), side_len(mirror_hlog, TILE_H));
                r.kind = KIND_DONE;
                r.sample = '0;
                awaited_results.push_back(r);
                n_runs++;
            end
            CMD_READ:
            begin
                r.kind = KIND_READ;
                r.sample = tile_model[addr][31:0];
                awaited_results.push_back(r);
                n_reads++;
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // input driver
    always @(posedge clk)
    begin
        bit take_next;
        cmd_beat_t b;
        if (rst_n)
        begin
            take_next = !in_valid;
            if (in_valid && in_ready)
            begin
                b.cmd = cmd;
                b.row = row_index;
                b.col = col_index;
                b.data = sample_in;
                predict_beat(b);
                take_next = 1'b1;
            end
            if (take_next)
            begin
                if (beat_queue.size() > 0 && (calm || $urandom_range(99) >= 12))
                begin
                    b = beat_queue.pop_front();
                    in_valid <= 1'b1;
                    cmd <= b.cmd;
                    row_index <= b.row;
                    col_index <= b.col;
                    sample_in <= b.data;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        result_beat_t e;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                    report_mismatch("result beat with nothing awaited");
                else
                begin
                    e = awaited_results.pop_front();
                    if (result_kind !== e.kind)
                        report_mismatch($sformatf("result_kind %0b, wanted %0b",
                            result_kind, e.kind));
                    if (sample_out !== e.sample)
                        report_mismatch($sformatf("sample_out %h, wanted %h",
                            sample_out, e.sample));
                end
            end
            if (hold_cnt > 0)
            begin
                hold_cnt <= hold_cnt - 1;
                out_ready <= 1'b0;
            end
            else if (hold_req && !hold_done)
            begin
                hold_done <= 1'b1;
                hold_cnt <= 300;
                out_ready <= 1'b0;
            end
            else
                out_ready <= calm || $urandom_range(99) >= 12;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired with %0d results awaited", awaited_results.size());
                $display("haar_lifting_2d_multilevel_core regression: fail");
                $finish;
            end
        end
    end

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            4: return $urandom_range(255) << 16;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_beat(logic [1:0] c, int r, int k, logic [31:0] d);
        cmd_beat_t b;
        b.cmd = c;
        b.row = r[5:0];
        b.col = k[5:0];
        b.data = d;
        if (c == CMD_WRITE)
            written[r * TILE_W + k] = 1'b1;
        beat_queue.push_back(b);
        n_pushed++;
    endtask

    // checked between edges so the driver and monitor have settled
    task automatic wait_drained();
        @(negedge clk);
        while (beat_queue.size() > 0 || in_valid || awaited_results.size() > 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_reg(logic [1:0] idx, int val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[2:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_WIDTH_LOG2: mirror_wlog = val;
            CFG_HEIGHT_LOG2: mirror_hlog = val;
            CFG_INVERSE: mirror_inverse = val[0];
            default: mirror_subtile = val[0];
        endcase
    endtask

    task automatic set_tile(int wl, int hl, bit inv, bit sub);
        wait_drained();
        set_reg(CFG_WIDTH_LOG2, wl);
        set_reg(CFG_HEIGHT_LOG2, hl);
        set_reg(CFG_INVERSE, inv);
        set_reg(CFG_SUBTILE, sub);
    endtask

    // every cell a run touches must hold a written sample
    task automatic cover_tile();
        int w;
        int h;
        w = side_len(mirror_wlog, TILE_W);
        h = side_len(mirror_hlog, TILE_H);
        for (int r = 0; r < h; r++)
            for (int k = 0; k < w; k++)
                if (!written[r * TILE_W + k])
                    push_beat(CMD_WRITE, r, k, pick_sample());
    endtask

    task automatic read_any(int w, int h);
        push_beat(CMD_READ, $urandom_range(h - 1), $urandom_range(w - 1), $urandom);
    endtask

    initial
    begin
        int w;
        int h;
        int r;
        int k;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        cmd = CMD_WRITE;
        row_index = '0;
        col_index = '0;
        sample_in = '0;
        out_ready = 1'b0;
        calm = 1'b0;
        hold_req = 1'b0;
        hold_done = 1'b0;
        hold_cnt = 0;
        quiet_cycles = 0;
        error_count = 0;
        n_pushed = 0;
        mirror_wlog = 6;
        mirror_hlog = 6;
        mirror_inverse = 1'b0;
        mirror_subtile = 1'b0;
        for (int i = 0; i < TILE_W * TILE_H; i++)
        begin
            tile_model[i] = 0;
            written[i] = 1'b0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, unused command, degenerate and non-square tiles
        set_tile(1, 1, 0, 0);
        push_beat(CMD_WRITE, 0, 0, 32'h7fff_ffff);
        push_beat(CMD_WRITE, 0, 1, 32'h8000_0000);
        push_beat(CMD_WRITE, 1, 0, 32'h8000_0000);
        push_beat(CMD_WRITE, 1, 1, 32'h7fff_ffff);
        push_beat(CMD_WRITE, 63, 63, 32'hffff_ffff);
        push_beat(CMD_READ, 63, 63, 32'h0);
        push_beat(CMD_NOP, 63, 63, 32'hffff_ffff);
        push_beat(CMD_RUN, 0, 0, 32'h0);
        push_beat(CMD_READ, 0, 1, 32'h0);
        push_beat(CMD_READ, 1, 0, 32'h0);
        set_tile(1, 1, 1, 0);
        push_beat(CMD_RUN, 0, 0, 32'h0);
        push_beat(CMD_READ, 0, 0, 32'h0);
        push_beat(CMD_READ, 1, 1, 32'h0);
        set_tile(0, 0, 1, 0);
        push_beat(CMD_RUN, 0, 0, 32'h0);
        push_beat(CMD_READ, 0, 0, 32'h0);
        set_tile(3, 0, 0, 1);
        cover_tile();
        push_beat(CMD_RUN, 0, 0, 32'h0);
        push_beat(CMD_READ, 0, 7, 32'h0);
        set_tile(0, 2, 1, 0);
        cover_tile();
        push_beat(CMD_RUN, 0, 0, 32'h0);
        push_beat(CMD_READ, 3, 0, 32'h0);

        // full-length lines; log2 size 7 clamps to 64
        calm = 1'b1;
        set_tile(7, 0, 0, 0);
        cover_tile();
        push_beat(CMD_RUN, 0, 0, 32'h0);
        for (int i = 0; i < 6; i++)
            read_any(64, 1);
        set_tile(0, 7, 1, 1);
        cover_tile();
        push_beat(CMD_RUN, 0, 0, 32'h0);
        for (int i = 0; i < 6; i++)
            read_any(1, 64);
        wait_drained();
        calm = 1'b0;

        // receiver holds off while reads keep coming
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++)
            read_any(64, 1);

        while (n_pushed < 500)
        begin
            if ($urandom_range(7) == 0)
            begin
                if ($urandom_range(1) == 0)
                    set_tile($urandom_range(7), 0, $urandom_range(1), $urandom_range(1));
                else
                    set_tile(0, $urandom_range(7), $urandom_range(1), $urandom_range(1));
            end
            else
                set_tile($urandom_range(3), $urandom_range(3), $urandom_range(1),
                    $urandom_range(1));
            calm = ($urandom_range(5) == 0);
            w = side_len(mirror_wlog, TILE_W);
            h = side_len(mirror_hlog, TILE_H);
            cover_tile();
            for (int i = 0; i < 20; i++)
            begin
                case ($urandom_range(9))
                    0, 1, 2:
                    begin
                        r = $urandom_range(63);
                        k = $urandom_range(63);
                        push_beat(CMD_WRITE, r, k, pick_sample());
                    end
                    3:
                        push_beat(CMD_NOP, $urandom_range(63), $urandom_range(63), $urandom);
                    4, 5:
                    begin
                        cover_tile();
                        push_beat(CMD_RUN, $urandom_range(63), $urandom_range(63), $urandom);
                    end
                    default:
                        read_any(w, h);
                endcase
            end
            cover_tile();
            push_beat(CMD_RUN, 0, 0, 32'h0);
            for (int i = 0; i < 4; i++)
                read_any(w, h);
        end
        calm = 1'b0;

        wait_drained();
        repeat (20) @(posedge clk);
        $display("covered %0d writes, %0d reads and %0d transform runs", n_writes, n_reads,
            n_runs);
        $display("tiles up to 8x8 and lines up to 64, both directions, subtile on and off");
        if (error_count == 0)
            $display("haar_lifting_2d_multilevel_core regression: pass");
        else
            $display("haar_lifting_2d_multilevel_core regression: fail");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/hlm_pkg.sv
hw/rtl/hlm_lift.sv
hw/rtl/hlm_sched.sv
hw/rtl/haar_lifting_2d_multilevel_core.sv
tb/tb_haar_lifting_2d_multilevel_core.sv
